// ----- src/sqltl_pkg.sv -----
// sqltl_pkg: shared types and constants of the sql token lexer
// token kinds, error codes, lexer modes, result beat and lexer state structs
// no dependencies
package sqltl_pkg;

    localparam int TOKEN_LIMIT    = 1024;
    localparam int WORD_MAX_LEN   = 127;
    localparam int NUMBER_MAX_LEN = 63;

    localparam int CNT_W = $clog2(TOKEN_LIMIT + 1);
    localparam int LEN_MAX = (WORD_MAX_LEN > NUMBER_MAX_LEN) ? WORD_MAX_LEN : NUMBER_MAX_LEN;
    localparam int LEN_W = $clog2(LEN_MAX + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_IDENT  = 4'd0,
        KIND_NUMBER = 4'd1,
        KIND_STRING = 4'd2,
        KIND_STAR   = 4'd3,
        KIND_COMMA  = 4'd4,
        KIND_LPAREN = 4'd5,
        KIND_RPAREN = 4'd6,
        KIND_DOT    = 4'd7,
        KIND_EQ     = 4'd8,
        KIND_LT     = 4'd9,
        KIND_LE     = 4'd10,
        KIND_GT     = 4'd11,
        KIND_GE     = 4'd12,
        KIND_NE     = 4'd13,
        KIND_EOF    = 4'd14
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_BANG  = 2'd1,
        ERR_CHAR  = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_IDENT      = 4'd1,
        MODE_NUMBER     = 4'd2,
        MODE_STRING     = 4'd3,
        MODE_STR_TAIL   = 4'd4,
        MODE_PEND_LT    = 4'd5,
        MODE_PEND_GT    = 4'd6,
        MODE_PEND_BANG  = 4'd7,
        MODE_PEND_MINUS = 4'd8,
        MODE_ERROR      = 4'd9
    } mode_t;

    typedef struct packed {
        kind_t        token_kind;
        logic [7:0]   text_byte;
        logic         has_byte;
        logic         token_done;
        err_t         error_code;
        logic         last_of_run;
    } res_t;

    typedef struct packed {
        mode_t              mode;
        logic [LEN_W-1:0]   text_length;
        logic [CNT_W-1:0]   token_count;
        logic               keep;
    } lex_state_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } step_out_t;

endpackage

// ----- src/sqltl_char_if.sv -----
// sqltl_char_if: character channel, one statement character per beat
// depends on nothing
interface sqltl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink (input valid, input char_byte, output ready);
endinterface

// ----- src/sqltl_tok_if.sv -----
// sqltl_tok_if: token channel, one token text byte or marker per beat
// depends on nothing
interface sqltl_tok_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_done;
    logic [1:0] error_code;
    logic       last_of_run;

    modport source (output valid, output token_kind, output text_byte, output has_byte,
                    output token_done, output error_code, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input text_byte, input has_byte,
                  input token_done, input error_code, input last_of_run, output ready);
endinterface

// ----- src/sqltl_step.sv -----
// sqltl_step: combinational lexer step, one character against the current state
// gives the next state and up to two result beats; uses sqltl_pkg
module sqltl_step (
    input  sqltl_pkg::lex_state_t cur,
    input  logic [7:0]            char_byte,
    output sqltl_pkg::lex_state_t nxt,
    output sqltl_pkg::step_out_t  res
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [sqltl_pkg::LEN_W:0] WORD_MAX =
        (sqltl_pkg::LEN_W+1)'(sqltl_pkg::WORD_MAX_LEN);
    localparam logic [sqltl_pkg::LEN_W:0] NUM_MAX =
        (sqltl_pkg::LEN_W+1)'(sqltl_pkg::NUMBER_MAX_LEN);
    localparam logic [sqltl_pkg::CNT_W-1:0] TOK_LIM =
        sqltl_pkg::CNT_W'(sqltl_pkg::TOKEN_LIMIT);

    typedef struct packed {
        sqltl_pkg::lex_state_t st;
        sqltl_pkg::step_out_t  o;
    } work_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // append a result beat; unless forced, dropped when the token is past the limit
    function automatic work_t put(work_t w, sqltl_pkg::kind_t k, logic [7:0] b, logic has,
                                  logic done, sqltl_pkg::err_t e, logic force_out);
        work_t            v;
        sqltl_pkg::res_t  r;
        v = w;
        r.token_kind  = k;
        r.text_byte   = b;
        r.has_byte    = has;
        r.token_done  = done;
        r.error_code  = e;
        r.last_of_run = 1'b0;
        if ((force_out || w.st.keep) && (w.o.n < 2'd2))
        begin
            if (w.o.n == 2'd0)
            begin
                v.o.r0 = r;
            end
            else
            begin
                v.o.r1 = r;
            end
            v.o.n = w.o.n + 2'd1;
        end
        return v;
    endfunction

    function automatic work_t start_token(work_t w);
        work_t v;
        v = w;
        v.st.keep = (w.st.token_count < TOK_LIM);
        if (v.st.keep)
        begin
            v.st.token_count = w.st.token_count + 1'b1;
        end
        return v;
    endfunction

    function automatic work_t append(work_t w, sqltl_pkg::kind_t k, logic [7:0] c,
                                     logic [sqltl_pkg::LEN_W:0] max_len,
                                     sqltl_pkg::mode_t after);
        work_t                      v;
        logic [sqltl_pkg::LEN_W:0]  inc;
        v = w;
        inc = {1'b0, w.st.text_length} + 1'b1;
        if (inc >= max_len)
        begin
            v = put(v, k, c, 1'b1, 1'b1, sqltl_pkg::ERR_NONE, 1'b0);
            v.st.mode = after;
            v.st.text_length = '0;
        end
        else
        begin
            v.st.text_length = inc[sqltl_pkg::LEN_W-1:0];
            v = put(v, k, c, 1'b1, 1'b0, sqltl_pkg::ERR_NONE, 1'b0);
        end
        return v;
    endfunction

    function automatic work_t begin_text(work_t w, sqltl_pkg::mode_t m, sqltl_pkg::kind_t k,
                                         logic [7:0] c, logic [sqltl_pkg::LEN_W:0] max_len);
        work_t v;
        v = start_token(w);
        v.st.mode = m;
        v.st.text_length = '0;
        v = append(v, k, c, max_len, sqltl_pkg::MODE_IDLE);
        return v;
    endfunction

    function automatic work_t end_marker(work_t w, sqltl_pkg::kind_t k);
        work_t v;
        v = put(w, k, CH_NUL, 1'b0, 1'b1, sqltl_pkg::ERR_NONE, 1'b0);
        v.st.mode = sqltl_pkg::MODE_IDLE;
        v.st.text_length = '0;
        return v;
    endfunction

    function automatic work_t raise_error(work_t w, sqltl_pkg::err_t e, logic [7:0] b);
        work_t v;
        v = put(w, sqltl_pkg::KIND_IDENT, b, 1'b1, 1'b0, e, 1'b1);
        v.st.mode = sqltl_pkg::MODE_ERROR;
        return v;
    endfunction

    function automatic work_t resolve_cmp(work_t w, logic [7:0] c, logic [7:0] first,
                                          sqltl_pkg::kind_t k1, sqltl_pkg::kind_t k2);
        work_t v;
        v = start_token(w);
        if (c == CH_EQ)
        begin
            v = put(v, k2, first, 1'b1, 1'b0, sqltl_pkg::ERR_NONE, 1'b0);
            v = put(v, k2, CH_EQ, 1'b1, 1'b1, sqltl_pkg::ERR_NONE, 1'b0);
        end
        else
        begin
            v = put(v, k1, first, 1'b1, 1'b1, sqltl_pkg::ERR_NONE, 1'b0);
        end
        v.st.mode = sqltl_pkg::MODE_IDLE;
        return v;
    endfunction

    function automatic work_t single(work_t w, sqltl_pkg::kind_t k, logic [7:0] c);
        work_t v;
        v = start_token(w);
        v = put(v, k, c, 1'b1, 1'b1, sqltl_pkg::ERR_NONE, 1'b0);
        return v;
    endfunction

    // character seen while no token is open
    function automatic work_t idle_char(work_t w, logic [7:0] c);
        work_t v;
        v = w;
        priority if (is_space(c) || (c == CH_SEMI))
        begin
            v = w;
        end
        else if (c == CH_COMMA) v = single(w, sqltl_pkg::KIND_COMMA, c);
        else if (c == CH_LPAR)  v = single(w, sqltl_pkg::KIND_LPAREN, c);
        else if (c == CH_RPAR)  v = single(w, sqltl_pkg::KIND_RPAREN, c);
        else if (c == CH_DOT)   v = single(w, sqltl_pkg::KIND_DOT, c);
        else if (c == CH_STAR)  v = single(w, sqltl_pkg::KIND_STAR, c);
        else if (c == CH_EQ)    v = single(w, sqltl_pkg::KIND_EQ, c);
        else if (c == CH_LT)    v.st.mode = sqltl_pkg::MODE_PEND_LT;
        else if (c == CH_GT)    v.st.mode = sqltl_pkg::MODE_PEND_GT;
        else if (c == CH_BANG)  v.st.mode = sqltl_pkg::MODE_PEND_BANG;
        else if (c == CH_MINUS) v.st.mode = sqltl_pkg::MODE_PEND_MINUS;
        else if (c == CH_QUOTE)
        begin
            v = start_token(w);
            v.st.mode = sqltl_pkg::MODE_STRING;
            v.st.text_length = '0;
        end
        else if (is_digit(c))
        begin
            v = begin_text(w, sqltl_pkg::MODE_NUMBER, sqltl_pkg::KIND_NUMBER, c, NUM_MAX);
        end
        else if (is_alpha(c) || (c == CH_UNDER))
        begin
            v = begin_text(w, sqltl_pkg::MODE_IDENT, sqltl_pkg::KIND_IDENT, c, WORD_MAX);
        end
        else
        begin
            v = raise_error(w, sqltl_pkg::ERR_CHAR, c);
        end
        return v;
    endfunction

    work_t w;
    logic  tail;

    always_comb
    begin
        w.st = cur;
        w.o  = '0;
        tail = 1'b1;
        unique case (cur.mode)
            sqltl_pkg::MODE_IDENT:
            begin
                if ((char_byte != CH_NUL) &&
                    (is_alpha(char_byte) || is_digit(char_byte) || (char_byte == CH_UNDER)))
                begin
                    w = append(w, sqltl_pkg::KIND_IDENT, char_byte, WORD_MAX,
                               sqltl_pkg::MODE_IDLE);
                    tail = 1'b0;
                end
                else
                begin
                    w = end_marker(w, sqltl_pkg::KIND_IDENT);
                end
            end
            sqltl_pkg::MODE_NUMBER:
            begin
                if (is_digit(char_byte) || (char_byte == CH_DOT))
                begin
                    w = append(w, sqltl_pkg::KIND_NUMBER, char_byte, NUM_MAX,
                               sqltl_pkg::MODE_IDLE);
                    tail = 1'b0;
                end
                else
                begin
                    w = end_marker(w, sqltl_pkg::KIND_NUMBER);
                end
            end
            sqltl_pkg::MODE_STRING:
            begin
                if (char_byte == CH_NUL)
                begin
                    w = end_marker(w, sqltl_pkg::KIND_STRING);
                end
                else if (char_byte == CH_QUOTE)
                begin
                    w = end_marker(w, sqltl_pkg::KIND_STRING);
                    tail = 1'b0;
                end
                else
                begin
                    w = append(w, sqltl_pkg::KIND_STRING, char_byte, WORD_MAX,
                               sqltl_pkg::MODE_STR_TAIL);
                    tail = 1'b0;
                end
            end
            sqltl_pkg::MODE_STR_TAIL:
            begin
                // one quote right after a truncated string is swallowed
                w.st.mode = sqltl_pkg::MODE_IDLE;
                tail = (char_byte != CH_QUOTE);
            end
            sqltl_pkg::MODE_PEND_LT:
            begin
                w = resolve_cmp(w, char_byte, CH_LT, sqltl_pkg::KIND_LT, sqltl_pkg::KIND_LE);
                tail = (char_byte != CH_EQ);
            end
            sqltl_pkg::MODE_PEND_GT:
            begin
                w = resolve_cmp(w, char_byte, CH_GT, sqltl_pkg::KIND_GT, sqltl_pkg::KIND_GE);
                tail = (char_byte != CH_EQ);
            end
            sqltl_pkg::MODE_PEND_BANG:
            begin
                if (char_byte == CH_EQ)
                begin
                    w = start_token(w);
                    w = put(w, sqltl_pkg::KIND_NE, CH_BANG, 1'b1, 1'b0, sqltl_pkg::ERR_NONE, 1'b0);
                    w = put(w, sqltl_pkg::KIND_NE, CH_EQ, 1'b1, 1'b1, sqltl_pkg::ERR_NONE, 1'b0);
                    w.st.mode = sqltl_pkg::MODE_IDLE;
                    tail = 1'b0;
                end
                else
                begin
                    w = raise_error(w, sqltl_pkg::ERR_BANG, CH_BANG);
                end
            end
            sqltl_pkg::MODE_PEND_MINUS:
            begin
                if (is_digit(char_byte))
                begin
                    w = begin_text(w, sqltl_pkg::MODE_NUMBER, sqltl_pkg::KIND_NUMBER, CH_MINUS,
                                   NUM_MAX);
                    if (w.st.mode == sqltl_pkg::MODE_NUMBER)
                    begin
                        w = append(w, sqltl_pkg::KIND_NUMBER, char_byte, NUM_MAX,
                                   sqltl_pkg::MODE_IDLE);
                    end
                    else
                    begin
                        w = idle_char(w, char_byte);
                    end
                    tail = 1'b0;
                end
                else
                begin
                    w = raise_error(w, sqltl_pkg::ERR_CHAR, CH_MINUS);
                end
            end
            sqltl_pkg::MODE_ERROR:
            begin
                tail = 1'b1;
            end
            default:
            begin
                w.st.mode = sqltl_pkg::MODE_IDLE;
            end
        endcase

        if (tail)
        begin
            if (w.st.mode == sqltl_pkg::MODE_ERROR)
            begin
                if (char_byte == CH_NUL)
                begin
                    w.st.mode = sqltl_pkg::MODE_IDLE;
                    w.st.text_length = '0;
                    w.st.token_count = '0;
                end
            end
            else if (char_byte == CH_NUL)
            begin
                w = start_token(w);
                w = put(w, sqltl_pkg::KIND_EOF, CH_NUL, 1'b0, 1'b1, sqltl_pkg::ERR_NONE, 1'b0);
                w.st.mode = sqltl_pkg::MODE_IDLE;
                w.st.text_length = '0;
                w.st.token_count = '0;
            end
            else
            begin
                w = idle_char(w, char_byte);
            end
        end

        // mark the final beat of this character
        if (w.o.n == 2'd1)
        begin
            w.o.r0.last_of_run = 1'b1;
        end
        else if (w.o.n == 2'd2)
        begin
            w.o.r1.last_of_run = 1'b1;
        end
    end

    assign nxt = w.st;
    assign res = w.o;

endmodule

// ----- src/sql_token_lexer_unit.sv -----
// sql_token_lexer_unit: top level of the sql token lexer
// holds the lexer state and a small result queue; uses sqltl_pkg, sqltl_char_if,
// sqltl_tok_if and sqltl_step
//
//  channel  | role   | beat
//  ---------+--------+---------------------------------------------------------
//  chars    | sink   | one statement character, byte 0 ends the statement
//  tokens   | source | one token text byte or bare end marker, with kind and flags
//
// each accepted character goes through the lexer step, one table-like pass from the
// state registers and the incoming byte, and its zero to two result beats are written
// into a four-entry result queue in the same edge. the token port drains one beat per
// cycle while tokens.ready is high, so a character that gives two beats (<= >= != and a few
// token ends) fills two queue slots. chars.ready is high while at least two queue slots
// are free, so characters keep flowing while earlier beats wait on tokens.ready.
// reset returns the lexer to idle with a zero token count and empties the queue.
module sql_token_lexer_unit (
    input  logic         clk,
    input  logic         rst_n,
    sqltl_char_if.sink   chars,
    sqltl_tok_if.source  tokens
);

    sqltl_pkg::lex_state_t  state_reg;
    sqltl_pkg::lex_state_t  state_next;
    sqltl_pkg::step_out_t   step_res;

    // result queue, written up to two beats per character
    sqltl_pkg::res_t                 fifo_mem [sqltl_pkg::FIFO_DEPTH];
    logic [sqltl_pkg::PTR_W-1:0]     wr_ptr_reg;
    logic [sqltl_pkg::PTR_W-1:0]     wr_ptr_next;
    logic [sqltl_pkg::PTR_W-1:0]     rd_ptr_reg;
    logic [sqltl_pkg::PTR_W-1:0]     rd_ptr_next;
    logic [sqltl_pkg::FCNT_W-1:0]    count_reg;
    logic [sqltl_pkg::FCNT_W-1:0]    count_next;
    logic [sqltl_pkg::PTR_W-1:0]     wr_ptr_plus1;

    logic                            in_fire;
    logic                            out_fire;
    logic [1:0]                      push_n;
    sqltl_pkg::res_t                 head;

    sqltl_step u_step (
        .cur       (state_reg),
        .char_byte (chars.char_byte),
        .nxt       (state_next),
        .res       (step_res)
    );

    // room for the worst case of two beats per character
    assign chars.ready = (count_reg <= sqltl_pkg::FCNT_W'(sqltl_pkg::FIFO_DEPTH - 2));
    assign in_fire     = chars.valid && chars.ready;
    assign out_fire    = tokens.valid && tokens.ready;
    assign push_n      = in_fire ? step_res.n : 2'd0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sqltl_pkg::PTR_W'(push_n);
        rd_ptr_next = out_fire ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + sqltl_pkg::FCNT_W'(push_n)
                    - sqltl_pkg::FCNT_W'(out_fire);
    end

    // lexer state advances only on an accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= sqltl_pkg::MODE_IDLE;
            state_reg.text_length <= '0;
            state_reg.token_count <= '0;
            state_reg.keep        <= 1'b1;
            wr_ptr_reg            <= '0;
            rd_ptr_reg            <= '0;
            count_reg             <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= step_res.r0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_plus1] <= step_res.r1;
        end
    end

    assign head = fifo_mem[rd_ptr_reg];

    assign tokens.valid       = (count_reg != '0);
    assign tokens.token_kind  = head.token_kind;
    assign tokens.text_byte   = head.text_byte;
    assign tokens.has_byte    = head.has_byte;
    assign tokens.token_done  = head.token_done;
    assign tokens.error_code  = head.error_code;
    assign tokens.last_of_run = head.last_of_run;

`ifndef ASSERT_OFF
    // the queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sqltl_pkg::FCNT_W'(sqltl_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // statement end always clears the token count
    a_eos_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (chars.char_byte == 8'h00)) |=> (state_reg.token_count == '0))
        else $error("token count not cleared at statement end");

    // while skipping after an error, characters give no beats
    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (state_reg.mode == sqltl_pkg::MODE_ERROR)) |-> (step_res.n == 2'd0))
        else $error("beat produced while skipping after an error");
`endif

endmodule
